// ===== rtl/ase_pkg.sv =====
package ase_pkg;

  localparam int unsigned MaxActivitiesDef = 16;
  localparam int unsigned TimeBitsDef      = 16;

  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] finish_time;
    logic        last_activity;
  } act_req_t;

  typedef struct packed {
    logic [15:0] chosen_start;
    logic [15:0] chosen_finish;
    logic [3:0]  chosen_position;
    logic        final_choice;
    logic        set_overflowed;
  } sel_req_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Controls from the selector / input side into the cell chain.
  typedef struct packed {
    logic accept;  // input request taken this cycle
    logic shift;   // move every entry one cell toward the head
    logic clear;   // set finished, reset count and drop flag
  } chain_ctrl_t;

  typedef struct packed {
    logic head_valid;
    logic dropped;
  } chain_stat_t;

endpackage

// ===== rtl/ase_cell.sv =====
module ase_cell #(
  parameter int unsigned TIME_BITS = ase_pkg::TimeBitsDef,
  parameter int unsigned POS_BITS  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ins,
  input  logic                 shift,
  input  logic [TIME_BITS-1:0] new_start,
  input  logic [TIME_BITS-1:0] new_finish,
  input  logic [POS_BITS-1:0]  new_pos,
  input  logic                 left_gx,
  input  logic                 left_valid,
  input  logic [TIME_BITS-1:0] left_start,
  input  logic [TIME_BITS-1:0] left_finish,
  input  logic [POS_BITS-1:0]  left_pos,
  input  logic                 right_valid,
  input  logic [TIME_BITS-1:0] right_start,
  input  logic [TIME_BITS-1:0] right_finish,
  input  logic [POS_BITS-1:0]  right_pos,
  output logic                 gx,
  output logic                 valid,
  output logic [TIME_BITS-1:0] start,
  output logic [TIME_BITS-1:0] finish,
  output logic [POS_BITS-1:0]  pos
);

  // Empty cells count as "later than anything", so the new entry lands at
  // the first cell whose finish is strictly greater (ties stay in load order).
  assign gx = !valid || (finish > new_finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      if (gx) begin
        valid <= left_gx ? left_valid : 1'b1;
      end
    end else if (shift) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (gx) begin
        if (left_gx) begin
          start  <= left_start;
          finish <= left_finish;
          pos    <= left_pos;
        end else begin
          start  <= new_start;
          finish <= new_finish;
          pos    <= new_pos;
        end
      end
    end else if (shift) begin
      start  <= right_start;
      finish <= right_finish;
      pos    <= right_pos;
    end
  end

endmodule

// ===== rtl/ase_chain.sv =====
module ase_chain #(
  parameter int unsigned MAX_ACTIVITIES = ase_pkg::MaxActivitiesDef,
  parameter int unsigned TIME_BITS      = ase_pkg::TimeBitsDef,
  parameter int unsigned POS_BITS       = $clog2(MAX_ACTIVITIES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ase_pkg::chain_ctrl_t   ctrl,
  input  logic [TIME_BITS-1:0]   new_start,
  input  logic [TIME_BITS-1:0]   new_finish,
  output ase_pkg::chain_stat_t   stat,
  output logic [TIME_BITS-1:0]   head_start,
  output logic [TIME_BITS-1:0]   head_finish,
  output logic [POS_BITS-1:0]    head_pos
);

  localparam int unsigned CntBits = $clog2(MAX_ACTIVITIES + 1);

  logic [CntBits-1:0] loaded_count;
  logic               dropped_flag;
  logic               full;
  logic               ins;

  logic                 gx_w    [MAX_ACTIVITIES];
  logic                 valid_w [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] start_w [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] finish_w[MAX_ACTIVITIES];
  logic [POS_BITS-1:0]  pos_w   [MAX_ACTIVITIES];

  assign full = (loaded_count == CntBits'(MAX_ACTIVITIES));
  assign ins  = ctrl.accept && !full;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      loaded_count <= '0;
      dropped_flag <= 1'b0;
    end else if (ctrl.accept) begin
      if (full) begin
        dropped_flag <= 1'b1;
      end else begin
        loaded_count <= loaded_count + CntBits'(1);
      end
    end
  end

  for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
    logic                 l_gx, l_valid, r_valid;
    logic [TIME_BITS-1:0] l_start, l_finish, r_start, r_finish;
    logic [POS_BITS-1:0]  l_pos, r_pos;

    if (i == 0) begin : g_head
      assign l_gx     = 1'b0;
      assign l_valid  = 1'b0;
      assign l_start  = '0;
      assign l_finish = '0;
      assign l_pos    = '0;
    end else begin : g_mid
      assign l_gx     = gx_w[i-1];
      assign l_valid  = valid_w[i-1];
      assign l_start  = start_w[i-1];
      assign l_finish = finish_w[i-1];
      assign l_pos    = pos_w[i-1];
    end

    if (i == MAX_ACTIVITIES - 1) begin : g_tail
      assign r_valid  = 1'b0;
      assign r_start  = '0;
      assign r_finish = '0;
      assign r_pos    = '0;
    end else begin : g_body
      assign r_valid  = valid_w[i+1];
      assign r_start  = start_w[i+1];
      assign r_finish = finish_w[i+1];
      assign r_pos    = pos_w[i+1];
    end

    ase_cell #(
      .TIME_BITS(TIME_BITS),
      .POS_BITS (POS_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ins         (ins),
      .shift       (ctrl.shift),
      .new_start   (new_start),
      .new_finish  (new_finish),
      .new_pos     (POS_BITS'(loaded_count)),
      .left_gx     (l_gx),
      .left_valid  (l_valid),
      .left_start  (l_start),
      .left_finish (l_finish),
      .left_pos    (l_pos),
      .right_valid (r_valid),
      .right_start (r_start),
      .right_finish(r_finish),
      .right_pos   (r_pos),
      .gx          (gx_w[i]),
      .valid       (valid_w[i]),
      .start       (start_w[i]),
      .finish      (finish_w[i]),
      .pos         (pos_w[i])
    );
  end

  assign stat.head_valid = valid_w[0];
  assign stat.dropped    = dropped_flag;
  assign head_start      = start_w[0];
  assign head_finish     = finish_w[0];
  assign head_pos        = pos_w[0];

endmodule

// ===== rtl/ase_select.sv =====
module ase_select #(
  parameter int unsigned TIME_BITS = ase_pkg::TimeBitsDef,
  parameter int unsigned POS_BITS  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 last_taken,
  input  ase_pkg::chain_stat_t stat,
  input  logic [TIME_BITS-1:0] head_start,
  input  logic [TIME_BITS-1:0] head_finish,
  input  logic [POS_BITS-1:0]  head_pos,
  output logic                 load_open,
  output logic                 shift,
  output logic                 clear,
  output logic                 sel_valid,
  input  logic                 sel_ready,
  output ase_pkg::sel_req_t    sel
);

  ase_pkg::state_t state, state_next;

  logic                 first;
  logic [TIME_BITS-1:0] last_taken_finish;
  logic                 pend_valid;
  logic [TIME_BITS-1:0] pend_start;
  logic [TIME_BITS-1:0] pend_finish;
  logic [POS_BITS-1:0]  pend_pos;

  logic out_free;
  logic take;
  logic grab;
  logic emit;
  logic emit_final;

  assign out_free = !sel_valid || sel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ase_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_open  = 1'b0;
    shift      = 1'b0;
    clear      = 1'b0;
    take       = 1'b0;
    grab       = 1'b0;
    emit       = 1'b0;
    emit_final = 1'b0;
    case (state)
      ase_pkg::ST_LOAD: begin
        load_open = 1'b1;
        if (last_taken) begin
          state_next = ase_pkg::ST_DRAIN;
        end
      end
      ase_pkg::ST_DRAIN: begin
        if (stat.head_valid) begin
          take = first || (head_start >= last_taken_finish);
          // a taken entry pushes the pending one out; wait if that can't go
          if (!(take && pend_valid && !out_free)) begin
            shift = 1'b1;
            grab  = take;
            emit  = take && pend_valid;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          emit_final = 1'b1;
          clear      = 1'b1;
          state_next = ase_pkg::ST_LOAD;
        end
      end
      default: state_next = ase_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first             <= 1'b0;
      pend_valid        <= 1'b0;
      last_taken_finish <= '0;
    end else begin
      if (last_taken && load_open) begin
        first <= 1'b1;
      end else if (grab) begin
        first <= 1'b0;
      end
      if (grab) begin
        pend_valid        <= 1'b1;
        last_taken_finish <= head_finish;
      end else if (emit_final) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grab) begin
      pend_start  <= head_start;
      pend_finish <= head_finish;
      pend_pos    <= head_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (emit) begin
      sel_valid <= 1'b1;
    end else if (sel_ready) begin
      sel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sel.chosen_start    <= 16'(pend_start);
      sel.chosen_finish   <= 16'(pend_finish);
      sel.chosen_position <= 4'(pend_pos);
      sel.final_choice    <= emit_final;
      sel.set_overflowed  <= stat.dropped;
    end
  end

endmodule

// ===== rtl/activity_selection_engine.sv =====
// Greedy activity selection (interval scheduling) engine.
//
// Input channel act_valid/act_ready/act carries one activity per request:
// start and finish time plus last_activity marking the end of a set.
// Activities enter a row of cells kept sorted by finish time (stable on
// ties) by parallel insertion, one request per cycle while loading.
// Requests beyond MAX_ACTIVITIES are dropped and the set is flagged.
//
// After the last request the cell row shifts toward its head one entry per
// cycle unless the drain is halted, and the selector keeps each entry whose
// start is at least the finish of the previously kept one (the first is
// always kept). A kept entry waits in a pending register until the next
// keep or the end of the set, so final_choice is known when it goes out on
// sel_valid/sel_ready. act_ready is low during the drain. A stalled
// receiver halts the drain when a new keep would overwrite a pending
// request, and holds the end of the set until the output register is free;
// results are never lost. Reset (rst, synchronous) empties the set and
// clears sel_valid; stored entries need no clearing.
module activity_selection_engine #(
  parameter int unsigned MAX_ACTIVITIES = ase_pkg::MaxActivitiesDef,
  parameter int unsigned TIME_BITS      = ase_pkg::TimeBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              act_valid,
  output logic              act_ready,
  input  ase_pkg::act_req_t act,
  output logic              sel_valid,
  input  logic              sel_ready,
  output ase_pkg::sel_req_t sel
);

  localparam int unsigned PosBits = $clog2(MAX_ACTIVITIES);

  ase_pkg::chain_ctrl_t ctrl;
  ase_pkg::chain_stat_t stat;

  logic [TIME_BITS-1:0] head_start;
  logic [TIME_BITS-1:0] head_finish;
  logic [PosBits-1:0]   head_pos;
  logic                 accept;
  logic                 load_open;
  logic                 shift;
  logic                 clear;

  assign act_ready = load_open;
  assign accept    = act_valid && load_open;

  assign ctrl.accept = accept;
  assign ctrl.shift  = shift;
  assign ctrl.clear  = clear;

  ase_chain #(
    .MAX_ACTIVITIES(MAX_ACTIVITIES),
    .TIME_BITS     (TIME_BITS),
    .POS_BITS      (PosBits)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .new_start  (TIME_BITS'(act.start_time)),
    .new_finish (TIME_BITS'(act.finish_time)),
    .stat       (stat),
    .head_start (head_start),
    .head_finish(head_finish),
    .head_pos   (head_pos)
  );

  ase_select #(
    .TIME_BITS(TIME_BITS),
    .POS_BITS (PosBits)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .last_taken (accept && act.last_activity),
    .stat       (stat),
    .head_start (head_start),
    .head_finish(head_finish),
    .head_pos   (head_pos),
    .load_open  (load_open),
    .shift      (shift),
    .clear      (clear),
    .sel_valid  (sel_valid),
    .sel_ready  (sel_ready),
    .sel        (sel)
  );

endmodule

// ===== bench/activity_selection_engine_test.sv =====
module activity_selection_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = ase_pkg::MaxActivitiesDef;

  // Clock, reset and block ports. Every driven signal starts at a known value.
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              act_valid = 1'b0;
  logic              act_ready;
  ase_pkg::act_req_t act       = '0;
  logic              sel_valid;
  logic              sel_ready = 1'b0;
  ase_pkg::sel_req_t sel;

  activity_selection_engine dut (
    .clk      (clk),
    .rst      (rst),
    .act_valid(act_valid),
    .act_ready(act_ready),
    .act      (act),
    .sel_valid(sel_valid),
    .sel_ready(sel_ready),
    .sel      (sel)
  );

  always #5 clk = ~clk;

  // Idle mix, percent of cycles: sender holding valid low, receiver holding
  // ready low. Changed per test phase.
  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;

  // Predictor state: the set loaded so far, kept sorted by finish time with
  // ties in load order, plus the drop flag and the finish of the last pick.
  logic [15:0] held_start  [Depth];
  logic [15:0] held_finish [Depth];
  logic [3:0]  held_pos    [Depth];
  int unsigned held_count   = 0;
  bit          held_dropped = 1'b0;
  logic [15:0] kept_finish  = '0;

  // Picks still to come out of the block, oldest first.
  ase_pkg::sel_req_t chosen_q[$];

  int unsigned n_requests      = 0;
  int unsigned n_sets          = 0;
  int unsigned n_overflow_sets = 0;
  int unsigned n_results       = 0;
  int unsigned n_errors        = 0;

  ase_pkg::sel_req_t want_sel;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 50) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Insert one accepted activity; on the last one of a set run the greedy
  // pass and queue every pick in sorted order.
  task automatic predict_activity(input ase_pkg::act_req_t a);
    ase_pkg::sel_req_t picks[$];
    ase_pkg::sel_req_t r;
    int unsigned       k;
    if (held_count < Depth) begin
      k = held_count;
      // strict compare keeps equal finishes in load order
      while (k > 0 && held_finish[k-1] > a.finish_time) begin
        held_start[k]  = held_start[k-1];
        held_finish[k] = held_finish[k-1];
        held_pos[k]    = held_pos[k-1];
        k--;
      end
      held_start[k]  = a.start_time;
      held_finish[k] = a.finish_time;
      held_pos[k]    = 4'(held_count);
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!a.last_activity) return;

    n_sets++;
    if (held_dropped) n_overflow_sets++;
    for (k = 0; k < held_count; k++) begin
      // first entry always taken; later ones need start >= last pick's finish
      if (k == 0 || held_start[k] >= kept_finish) begin
        r.chosen_start    = held_start[k];
        r.chosen_finish   = held_finish[k];
        r.chosen_position = held_pos[k];
        r.final_choice    = 1'b0;
        r.set_overflowed  = held_dropped;
        picks.push_back(r);
        kept_finish = held_finish[k];
      end
    end
    if (picks.size() > 0) picks[picks.size()-1].final_choice = 1'b1;
    foreach (picks[i]) chosen_q.push_back(picks[i]);
    held_count   = 0;
    held_dropped = 1'b0;
  endtask

  // Receiver: ready changes on the falling edge per the current stall mix.
  always @(negedge clk) begin
    sel_ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && sel_valid && sel_ready) begin
      n_results++;
      if (chosen_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", sel));
      end else begin
        want_sel = chosen_q.pop_front();
        if (sel.chosen_start !== want_sel.chosen_start)
          report_mismatch($sformatf("chosen_start got %h want %h",
                                    sel.chosen_start, want_sel.chosen_start));
        if (sel.chosen_finish !== want_sel.chosen_finish)
          report_mismatch($sformatf("chosen_finish got %h want %h",
                                    sel.chosen_finish, want_sel.chosen_finish));
        if (sel.chosen_position !== want_sel.chosen_position)
          report_mismatch($sformatf("chosen_position got %h want %h",
                                    sel.chosen_position, want_sel.chosen_position));
        if (sel.final_choice !== want_sel.final_choice)
          report_mismatch($sformatf("final_choice got %b want %b",
                                    sel.final_choice, want_sel.final_choice));
        if (sel.set_overflowed !== want_sel.set_overflowed)
          report_mismatch($sformatf("set_overflowed got %b want %b",
                                    sel.set_overflowed, want_sel.set_overflowed));
      end
    end
  end

  // Send one request. Valid stays high after acceptance until the next
  // falling edge, where it either carries the next request or drops.
  task automatic send_activity(input ase_pkg::act_req_t a);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      act_valid <= 1'b0;
      @(negedge clk);
    end
    act_valid <= 1'b1;
    act       <= a;
    do @(posedge clk); while (!act_ready);
    n_requests++;
    predict_activity(a);
  endtask

  function automatic ase_pkg::act_req_t make_act(input logic [15:0] s,
                                                 input logic [15:0] f,
                                                 input bit last_one);
    ase_pkg::act_req_t a;
    a.start_time    = s;
    a.finish_time   = f;
    a.last_activity = last_one;
    return a;
  endfunction

  // Narrow times give dense overlaps and frequent ties; wide ones hit every
  // bit. Some narrow requests finish before they start (broken intervals).
  function automatic ase_pkg::act_req_t random_activity(input bit last_one,
                                                        input bit wide);
    logic [15:0] s;
    logic [15:0] f;
    if (wide) begin
      s = 16'($urandom);
      f = 16'($urandom);
    end else begin
      s = 16'($urandom_range(0, 40));
      f = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 40))
                                   : s + 16'($urandom_range(0, 12));
    end
    return make_act(s, f, last_one);
  endfunction

  // Hold off the sender until every pick has come out, then let the drain
  // finish.
  task automatic wait_results_drained();
    @(negedge clk);
    act_valid <= 1'b0;
    while (chosen_q.size() != 0) @(posedge clk);
    repeat (Depth + 8) @(posedge clk);
  endtask

  // One-activity sets at the field extremes, including start after finish.
  task automatic test_single_extremes();
    send_activity(make_act(16'h0000, 16'h0000, 1'b1));
    send_activity(make_act(16'hFFFF, 16'hFFFF, 1'b1));
    send_activity(make_act(16'hFFFF, 16'h0000, 1'b1));
  endtask

  // Equal finishes keep load order; a start equal to the last pick's finish
  // is taken.
  task automatic test_tie_order();
    send_activity(make_act(16'd5,  16'd10, 1'b0));
    send_activity(make_act(16'd2,  16'd10, 1'b0));
    send_activity(make_act(16'd10, 16'd10, 1'b0));
    send_activity(make_act(16'd0,  16'd3,  1'b1));
  endtask

  // Loaded out of finish order so insertion has to move entries.
  task automatic test_greedy_mix();
    send_activity(make_act(16'd8, 16'd9, 1'b0));
    send_activity(make_act(16'd0, 16'd6, 1'b0));
    send_activity(make_act(16'd3, 16'd5, 1'b0));
    send_activity(make_act(16'd1, 16'd4, 1'b1));
  endtask

  // Full store, then a dropped request that carries the last flag.
  task automatic test_overflow();
    for (int unsigned i = 0; i < Depth; i++) begin
      send_activity(random_activity(1'b0, 1'b0));
    end
    send_activity(make_act(16'h0000, 16'h0001, 1'b1));
  endtask

  // Well-formed sets with random content; mostly small, some up to the store's
  // depth, a few running past it.
  task automatic test_random_sets(input int unsigned quota, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned sent;
    int unsigned size;
    int unsigned roll;
    bit          wide;
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    sent            = 0;
    while (sent < quota) begin
      roll = $urandom_range(99);
      if (roll < 80)      size = $urandom_range(1, 6);
      else if (roll < 94) size = $urandom_range(7, Depth);
      else                size = $urandom_range(Depth + 1, Depth + 3);
      wide = ($urandom_range(3) == 0);
      for (int unsigned i = 0; i < size; i++) begin
        send_activity(random_activity(i == size - 1, wide));
      end
      sent += size;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_extremes();
    test_tie_order();
    test_greedy_mix();
    test_overflow();
    wait_results_drained();

    test_random_sets(30, 0, 0);
    wait_results_drained();
    test_random_sets(30, 55, 0);
    wait_results_drained();
    test_random_sets(30, 0, 55);
    wait_results_drained();
    test_random_sets(30, 28, 28);
    wait_results_drained();

    $display("Covered %0d requests in %0d sets (%0d with drops), %0d picks checked.",
             n_requests, n_sets, n_overflow_sets, n_results);
    $display("Idle mixes: none, sender 55%%, receiver 55%%, both 28%%; %0d mismatches.",
             n_errors);
    if (n_errors == 0 && chosen_q.size() == 0) begin
      $display("activity_selection_engine regression: pass");
    end else begin
      $display("activity_selection_engine regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("activity_selection_engine regression: fail");
    $finish;
  end

endmodule

// ===== activity_selection_engine.f =====
rtl/ase_pkg.sv
rtl/ase_cell.sv
rtl/ase_chain.sv
rtl/ase_select.sv
rtl/activity_selection_engine.sv
bench/activity_selection_engine_test.sv
